@@ hw/rtl/circular_ordered_list_engine_unit_assert.svh @@
`ifndef CIRCULAR_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define CIRCULAR_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define COLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define COLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cole_pkg.sv @@
package cole_pkg;

  localparam int CAPACITY = 64;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 7;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [LEN_W-1:0]        len_t;
  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]      count_t;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

endpackage

@@ hw/rtl/circular_ordered_list_engine_unit.sv @@
// Append: an empty or full list goes straight to the result state; any other list
// first links the new slot behind the tail. Remove: an empty list goes straight to
// the result; else the head is read, then links walk one a cycle past the head.
// An output stall holds the result in both. Next word is taken in the cycle after
// the result loads. Reset clears head, tail, count and slot occupancy; the value
// and link memories are not cleared and are only read after being written.
`include "circular_ordered_list_engine_unit_assert.svh"

module circular_ordered_list_engine_unit
  import cole_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   in_command,
  input  value_t in_value,
  output logic   out_valid,
  input  logic   out_stall,
  output logic   out_accepted,
  output logic   out_found,
  output value_t out_removed_value,
  output count_t out_entry_count
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_APP_LINK = 3'd1;
  localparam logic [2:0] S_HEAD     = 3'd2;
  localparam logic [2:0] S_WALK     = 3'd3;
  localparam logic [2:0] S_FIN      = 3'd4;

  localparam len_t FULL_LEN = LEN_W'(CAPACITY);

  // Slot store
  value_t val_mem_r  [CAPACITY];
  slot_t  link_mem_r [CAPACITY];
  value_t rd_val_r;
  slot_t  rd_link_r;

  logic [2:0]          state_r, state_nxt;
  logic [CAPACITY-1:0] used_r, used_nxt;
  slot_t               head_r, head_nxt;
  slot_t               tail_r, tail_nxt;
  len_t                len_r, len_nxt;
  slot_t               prev_r, prev_nxt;
  slot_t               cur_r, cur_nxt;
  slot_t               new_r, new_nxt;
  value_t              key_r, key_nxt;
  logic                res_acc_r, res_acc_nxt;
  logic                res_fnd_r, res_fnd_nxt;
  value_t              res_val_r, res_val_nxt;

  logic   out_valid_r;
  logic   out_acc_r;
  logic   out_fnd_r;
  value_t out_val_r;
  count_t out_cnt_r;

  slot_t  free_slot;
  slot_t  rd_addr;
  logic   val_we;
  logic   link_we;
  slot_t  link_waddr;
  slot_t  link_wdata;
  logic   out_load;

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    len_nxt     = len_r;
    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    new_nxt     = new_r;
    key_nxt     = key_r;
    res_acc_nxt = res_acc_r;
    res_fnd_nxt = res_fnd_r;
    res_val_nxt = res_val_r;
    rd_addr     = head_r;
    val_we      = 1'b0;
    link_we     = 1'b0;
    link_waddr  = free_slot;
    link_wdata  = head_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt     = in_value;
          res_acc_nxt = 1'b1;
          res_fnd_nxt = 1'b0;
          res_val_nxt = '0;
          if (in_command == CMD_APPEND) begin
            if (len_r == FULL_LEN) begin
              res_acc_nxt = 1'b0;
              state_nxt   = S_FIN;
            end else begin
              val_we              = 1'b1;
              link_we             = 1'b1;
              used_nxt[free_slot] = 1'b1;
              len_nxt             = len_r + LEN_W'(1);
              if (len_r == '0) begin
                // sole entry links to itself
                link_wdata = free_slot;
                head_nxt   = free_slot;
                tail_nxt   = free_slot;
                state_nxt  = S_FIN;
              end else begin
                new_nxt   = free_slot;
                state_nxt = S_APP_LINK;
              end
            end
          end else if (len_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            rd_addr   = head_r;
            state_nxt = S_HEAD;
          end
        end
      end
      S_APP_LINK: begin
        link_we    = 1'b1;
        link_waddr = tail_r;
        link_wdata = new_r;
        tail_nxt   = new_r;
        state_nxt  = S_FIN;
      end
      S_HEAD: begin
        if (rd_val_r == key_r) begin
          res_fnd_nxt      = 1'b1;
          res_val_nxt      = key_r;
          used_nxt[head_r] = 1'b0;
          len_nxt          = len_r - LEN_W'(1);
          if (len_r == LEN_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            // close the ring past the old head
            head_nxt   = rd_link_r;
            link_we    = 1'b1;
            link_waddr = tail_r;
            link_wdata = rd_link_r;
          end
          state_nxt = S_FIN;
        end else if (rd_link_r == head_r) begin
          state_nxt = S_FIN;
        end else begin
          prev_nxt  = head_r;
          cur_nxt   = rd_link_r;
          rd_addr   = rd_link_r;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (rd_val_r == key_r) begin
          res_fnd_nxt     = 1'b1;
          res_val_nxt     = key_r;
          used_nxt[cur_r] = 1'b0;
          len_nxt         = len_r - LEN_W'(1);
          link_we         = 1'b1;
          link_waddr      = prev_r;
          link_wdata      = rd_link_r;
          if (tail_r == cur_r) begin
            tail_nxt = prev_r;
          end
          state_nxt = S_FIN;
        end else if (rd_link_r == head_r) begin
          state_nxt = S_FIN;
        end else begin
          // advance one entry
          prev_nxt = cur_r;
          cur_nxt  = rd_link_r;
          rd_addr  = rd_link_r;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem_r[free_slot] <= in_value;
    end
    if (link_we) begin
      link_mem_r[link_waddr] <= link_wdata;
    end
    rd_val_r  <= val_mem_r[rd_addr];
    rd_link_r <= link_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      len_r   <= len_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r    <= prev_nxt;
    cur_r     <= cur_nxt;
    new_r     <= new_nxt;
    key_r     <= key_nxt;
    res_acc_r <= res_acc_nxt;
    res_fnd_r <= res_fnd_nxt;
    res_val_r <= res_val_nxt;
    if (out_load) begin
      out_acc_r <= res_acc_r;
      out_fnd_r <= res_fnd_r;
      out_val_r <= res_val_r;
      out_cnt_r <= COUNT_W'(len_r);
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_found         = out_fnd_r;
  assign out_removed_value = out_val_r;
  assign out_entry_count   = out_cnt_r;

  `COLE_ASSERT_NOW(a_len_bound, 1'b1, len_r <= FULL_LEN, "list length above capacity")
  `COLE_ASSERT_NOW(a_len_matches_used, 1'b1,
                   $countones(used_r) == 32'(len_r), "occupancy and length disagree")
  `COLE_ASSERT_NOW(a_empty_ends, len_r == '0, (head_r == '0) && (tail_r == '0),
                   "empty list with nonzero head or tail")
  `COLE_ASSERT_NOW(a_ends_used, len_r != '0, used_r[head_r] && used_r[tail_r],
                   "head or tail slot not in use")
  `COLE_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE,
                    "accepted word did not start work")

endmodule
